// ===== design/calendar_odometer_overspeed_blinker_unit_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef CALENDAR_ODOMETER_OVERSPEED_BLINKER_UNIT_ASSERT_SVH
`define CALENDAR_ODOMETER_OVERSPEED_BLINKER_UNIT_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define COBU_ASSERT_SAME(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("cobu assertion failed");

// The condition must hold in the cycle after the trigger.
`define COBU_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("cobu assertion failed");

`endif

// ===== design/cobu_pkg.sv =====
package cobu_pkg;

  localparam int DISTANCE_BITS_DEFAULT = 16;

  localparam logic ACTION_TICK  = 1'b0;
  localparam logic ACTION_CHECK = 1'b1;

  localparam logic [7:0] CFG_LIMIT_KMH      = 8'd0;
  localparam logic [7:0] CFG_LIMITER_ENABLE = 8'd1;

  localparam logic [5:0]  SEC_LAST   = 6'd59;
  localparam logic [5:0]  SEC_WRAP   = 6'd60;
  localparam logic [5:0]  SAVE_A     = 6'd20;
  localparam logic [5:0]  SAVE_B     = 6'd40;
  localparam logic [5:0]  MIN_LAST   = 6'd59;
  localparam logic [4:0]  HOUR_LAST  = 5'd23;
  localparam logic [4:0]  DAY_LAST   = 5'd29;
  localparam logic [3:0]  MONTH_LAST = 4'd11;

  localparam logic [4:0]  DAY_RESET   = 5'd10;
  localparam logic [3:0]  MONTH_RESET = 4'd6;
  localparam logic [15:0] YEAR_RESET  = 16'd2024;

  localparam int OUT_DATA_BITS = 64;
  localparam int OUT_RELAY_LSB = 0;
  localparam int OUT_SEC_LSB   = 1;
  localparam int OUT_MIN_LSB   = 7;
  localparam int OUT_HOUR_LSB  = 13;
  localparam int OUT_DAY_LSB   = 18;
  localparam int OUT_MONTH_LSB = 23;
  localparam int OUT_YEAR_LSB  = 27;
  localparam int OUT_DIST_LSB  = 43;
  localparam int OUT_SAVE_BIT  = 59;
  localparam int OUT_MON_BIT   = 60;

  typedef struct packed {
    logic        armed;
    logic        phase;
    logic        relay;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } cobu_state_t;

  // Speed over 50 for an 8-bit speed: multiply by 41 and drop 11 bits.
  function automatic logic [2:0] speed_div50(input logic [7:0] speed);
    logic [13:0] prod;
    prod = 14'(speed) * 14'd41;
    return prod[13:11];
  endfunction

endpackage

// ===== design/calendar_odometer_overspeed_blinker_unit.sv =====
// Calendar, odometer and overspeed relay blinker. Each input word is either a
// one-second tick (tuser 0) or a speed check (tuser 1) and yields exactly one
// output word with the relay level, the calendar (30-day months, 12 months,
// 16-bit year), the low 16 bits of the distance count, and the save and
// monitor pulses. A word is registered on entry and its result is computed in
// one pass into the output register, so a new word is taken every cycle while
// the output side keeps up; the result is written into the output register as
// the word leaves the input register. Writes on the cfg channel are always
// taken and should be made while no word is in flight.
module calendar_odometer_overspeed_blinker_unit import cobu_pkg::*; #(
  parameter int DISTANCE_BITS = DISTANCE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // speed [7:0], drive_gear [8], zero [15:9]
  input  logic [15:0] s_axis_tdata,
  // action [0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // relay [0], second_count [6:1], minute_count [12:7], hour_count [17:13],
  // day_count [22:18], month_count [26:23], year_count [42:27],
  // distance_count [58:43], save_due [59], monitor_due [60], zero [63:61]
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic                     in_valid;
  logic                     in_action;
  logic [7:0]               in_speed;
  logic                     in_drive;
  logic                     advance;

  logic [7:0]               limit_kmh;
  logic                     limiter_enable;

  cobu_state_t              state;
  cobu_state_t              state_next;
  logic [DISTANCE_BITS-1:0] odo;
  logic [DISTANCE_BITS-1:0] odo_next;
  logic [DISTANCE_BITS+15:0] odo_ext;
  logic                     save_due;
  logic                     monitor_due;
  logic [OUT_DATA_BITS-1:0] out_word;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action <= s_axis_tuser;
      in_speed  <= s_axis_tdata[7:0];
      in_drive  <= s_axis_tdata[8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_kmh      <= '0;
      limiter_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_LIMIT_KMH) begin
        limit_kmh <= cfg_data;
      end else if (cfg_index == CFG_LIMITER_ENABLE) begin
        limiter_enable <= cfg_data[0];
      end
    end
  end

  cobu_calc #(
    .DISTANCE_BITS(DISTANCE_BITS)
  ) u_calc (
    .cur            (state),
    .odo            (odo),
    .action         (in_action),
    .speed          (in_speed),
    .drive_gear     (in_drive),
    .limit_kmh      (limit_kmh),
    .limiter_enable (limiter_enable),
    .nxt            (state_next),
    .odo_next       (odo_next),
    .save_due       (save_due),
    .monitor_due    (monitor_due)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.armed <= 1'b0;
      state.phase <= 1'b0;
      state.relay <= 1'b0;
      state.sec   <= '0;
      state.min   <= '0;
      state.hour  <= '0;
      state.day   <= DAY_RESET;
      state.month <= MONTH_RESET;
      state.year  <= YEAR_RESET;
      odo         <= '0;
    end else if (advance) begin
      state <= state_next;
      odo   <= odo_next;
    end
  end

  assign odo_ext = {16'd0, odo_next};

  always_comb begin
    out_word = '0;
    out_word[OUT_RELAY_LSB]                = state_next.relay;
    out_word[OUT_SEC_LSB +: 6]             = state_next.sec;
    out_word[OUT_MIN_LSB +: 6]             = state_next.min;
    out_word[OUT_HOUR_LSB +: 5]            = state_next.hour;
    out_word[OUT_DAY_LSB +: 5]             = state_next.day;
    out_word[OUT_MONTH_LSB +: 4]           = state_next.month;
    out_word[OUT_YEAR_LSB +: 16]           = state_next.year;
    out_word[OUT_DIST_LSB +: 16]           = odo_ext[15:0];
    out_word[OUT_SAVE_BIT]                 = save_due;
    out_word[OUT_MON_BIT]                  = monitor_due;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= out_word;
    end
  end

endmodule

// ===== design/cobu_calc.sv =====
module cobu_calc import cobu_pkg::*; #(
  parameter int DISTANCE_BITS = DISTANCE_BITS_DEFAULT
) (
  input  cobu_state_t              cur,
  input  logic [DISTANCE_BITS-1:0] odo,
  input  logic                     action,
  input  logic [7:0]               speed,
  input  logic                     drive_gear,
  input  logic [7:0]               limit_kmh,
  input  logic                     limiter_enable,
  output cobu_state_t              nxt,
  output logic [DISTANCE_BITS-1:0] odo_next,
  output logic                     save_due,
  output logic                     monitor_due
);

  logic [5:0] sec_inc;

  assign sec_inc = cur.sec + 6'd1;

  always_comb begin
    nxt         = cur;
    odo_next    = odo;
    save_due    = 1'b0;
    monitor_due = 1'b0;
    if (action == ACTION_TICK) begin
      if (cur.armed) begin
        nxt.phase = ~cur.phase;
        nxt.relay = ~cur.phase;
      end
      if (sec_inc == SAVE_A || sec_inc == SAVE_B || sec_inc == SEC_WRAP) begin
        save_due    = 1'b1;
        monitor_due = drive_gear;
      end
      if (cur.sec >= SEC_LAST) begin
        nxt.sec = '0;
        if (cur.min == MIN_LAST) begin
          nxt.min = '0;
          if (cur.hour == HOUR_LAST) begin
            nxt.hour = '0;
            if (cur.day == DAY_LAST) begin
              nxt.day = '0;
              if (cur.month == MONTH_LAST) begin
                nxt.month = '0;
                nxt.year  = cur.year + 16'd1;
              end else begin
                nxt.month = cur.month + 4'd1;
              end
            end else begin
              nxt.day = cur.day + 5'd1;
            end
          end else begin
            nxt.hour = cur.hour + 5'd1;
          end
        end else begin
          nxt.min = cur.min + 6'd1;
        end
      end else begin
        nxt.sec = sec_inc;
      end
      if (drive_gear) begin
        odo_next = odo + DISTANCE_BITS'(1) + DISTANCE_BITS'(speed_div50(speed));
      end
    end else begin
      if (!limiter_enable) begin
        nxt.armed = 1'b0;
        nxt.relay = 1'b0;
      end else if (drive_gear) begin
        if (speed > limit_kmh) begin
          nxt.armed = 1'b1;
        end else begin
          nxt.armed = 1'b0;
          nxt.relay = 1'b0;
        end
      end
    end
  end

endmodule

// ===== design/cobu_checker.sv =====
`include "calendar_odometer_overspeed_blinker_unit_assert.svh"

module cobu_checker import cobu_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  logic [5:0] sec_out;
  logic       save_out;
  logic       mon_out;
  logic       out_stall;
  logic       sec_at_save;

  assign sec_out     = m_axis_tdata[OUT_SEC_LSB +: 6];
  assign save_out    = m_axis_tdata[OUT_SAVE_BIT];
  assign mon_out     = m_axis_tdata[OUT_MON_BIT];
  assign out_stall   = m_axis_tvalid && !m_axis_tready;
  assign sec_at_save = sec_out == SAVE_A || sec_out == SAVE_B || sec_out == 6'd0;

  // A stalled result word stays put.
  `COBU_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // The seconds count never leaves its range.
  `COBU_ASSERT_SAME(a_sec_range, clk, rst, m_axis_tvalid, sec_out <= SEC_LAST)

  // A save pulse only comes with the seconds at a multiple of twenty.
  `COBU_ASSERT_SAME(a_save_sec, clk, rst, m_axis_tvalid && save_out, sec_at_save)

  // The monitor pulse is a subset of the save pulse.
  `COBU_ASSERT_SAME(a_mon_save, clk, rst, m_axis_tvalid && mon_out, save_out)

endmodule

bind calendar_odometer_overspeed_blinker_unit cobu_checker u_cobu_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
